FILE: rtl/core/osc_pkg.sv
// ---------------------------------------------------------------------------
// OSC parser package
// Shared types, codes and helpers for the OSC message parser.
// ---------------------------------------------------------------------------
`default_nettype none
package osc_pkg;
	localparam int MaxArgsDefault = 32;

	localparam logic [2:0] KIND_ADDR = 3'd0;
	localparam logic [2:0] KIND_SCALAR = 3'd1;
	localparam logic [2:0] KIND_STR = 3'd2;
	localparam logic [2:0] KIND_BLOB = 3'd3;
	localparam logic [2:0] KIND_DONE = 3'd4;

	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_ADDR_SHORT = 4'd1;
	localparam logic [3:0] ST_TAGS_SHORT = 4'd2;
	localparam logic [3:0] ST_TOO_MANY = 4'd3;
	localparam logic [3:0] ST_INT_SHORT = 4'd4;
	localparam logic [3:0] ST_FLOAT_SHORT = 4'd5;
	localparam logic [3:0] ST_BSIZE_SHORT = 4'd6;
	localparam logic [3:0] ST_BDATA_SHORT = 4'd7;
	localparam logic [3:0] ST_UNKNOWN = 4'd8;
	localparam logic [3:0] ST_OVERFLOW = 4'd9;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_I = 8'h69;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_S = 8'h73;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_TRUE = 8'h54;
	localparam logic [7:0] CH_FALSE = 8'h46;
	localparam logic [7:0] CH_NIL = 8'h4E;
	localparam logic [7:0] CH_INF = 8'h49;

	typedef enum logic [3:0] {
		PH_ADDR, PH_ADDR_PAD, PH_COMMA, PH_RAW, PH_TAGS, PH_TAGS_PAD, PH_INT,
		PH_FLOAT, PH_STR, PH_STR_PAD, PH_BSIZE, PH_BDATA, PH_BPAD, PH_DONE,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [5:0] arg_number;
		logic [7:0] tag;
		logic [31:0] word_value;
		logic [7:0] payload_byte;
		logic field_end;
		logic [3:0] status;
		logic last_result;
	} result_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic final_byte;
	} item_t;

	// Datapath commands from the controller.
	typedef struct packed {
		logic clear;
		logic shift_word;
		logic clear_word;
		logic load_blob;
		logic dec_blob;
		logic store_tag;
		logic inc_arg;
		logic zero_arg;
		logic set_too_many;
		logic set_unknown;
	} dp_cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic [7:0] cur_tag;
		logic [31:0] word_next;
		logic blob_one;
		logic [5:0] tag_count;
		logic [5:0] cur_arg;
		logic tags_full;
		logic args_left;
		logic [3:0] err;
		logic [1:0] align;
	} dp_sts_t;

	function automatic logic is_dataless(input logic [7:0] t);
		return (t == CH_TRUE) || (t == CH_FALSE) || (t == CH_NIL) || (t == CH_INF);
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/osc_stream_if.sv
// ---------------------------------------------------------------------------
// OSC stream interface
// Valid and ready handshake carrying one payload beat.
// ---------------------------------------------------------------------------
`default_nettype none
interface osc_stream_if #(parameter type payload_t = logic [7:0]);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/osc_ram.sv
// ---------------------------------------------------------------------------
// OSC generic RAM
// Single write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module osc_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/core/osc_datapath.sv
// ---------------------------------------------------------------------------
// OSC parser datapath
// Tag store, argument counters, alignment counter, word collector, blob counter and error code.
// ---------------------------------------------------------------------------
`default_nettype none
module osc_datapath #(
	parameter int MaxArgs = osc_pkg::MaxArgsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [7:0] in_byte,
	input wire logic adv_align,
	input wire osc_pkg::dp_cmd_t cmd,
	output osc_pkg::dp_sts_t sts
);
	import osc_pkg::*;
	localparam int AW = (MaxArgs > 1) ? $clog2(MaxArgs) : 1;
	localparam logic [5:0] MaxArgsC = 6'(MaxArgs);

	logic [5:0] tag_count_q, cur_arg_q, rd_arg;
	logic [1:0] align_q;
	logic [31:0] word_q, blob_q;
	logic [3:0] err_q;
	logic [7:0] rdata;

	// The read address looks one argument ahead when the index moves, so the
	// registered read always shows the tag of the current argument.
	always_comb begin
		rd_arg = cur_arg_q;
		if (cmd.clear || cmd.zero_arg) begin
			rd_arg = '0;
		end else if (cmd.inc_arg) begin
			rd_arg = cur_arg_q + 6'd1;
		end
	end

	osc_ram #(.Width(8), .Depth(MaxArgs)) u_tags (
		.clk(clk),
		.we(cmd.store_tag && !sts.tags_full),
		.waddr(AW'(tag_count_q)),
		.wdata(in_byte),
		.raddr(AW'(rd_arg)),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_count_q <= '0;
			cur_arg_q <= '0;
			align_q <= '0;
			word_q <= '0;
			blob_q <= '0;
			err_q <= ST_OK;
		end else if (cmd.clear) begin
			tag_count_q <= '0;
			cur_arg_q <= '0;
			align_q <= '0;
			word_q <= '0;
			blob_q <= '0;
			err_q <= ST_OK;
		end else begin
			if (adv_align) begin
				align_q <= align_q + 2'd1;
			end
			if (cmd.store_tag && !sts.tags_full) begin
				tag_count_q <= tag_count_q + 6'd1;
			end
			cur_arg_q <= rd_arg;
			if (cmd.clear_word) begin
				word_q <= '0;
			end else if (cmd.shift_word) begin
				word_q <= sts.word_next;
			end
			if (cmd.load_blob) begin
				blob_q <= sts.word_next;
			end else if (cmd.dec_blob) begin
				blob_q <= blob_q - 32'd1;
			end
			if (cmd.set_too_many) begin
				err_q <= ST_TOO_MANY;
			end else if (cmd.set_unknown) begin
				err_q <= ST_UNKNOWN;
			end
		end
	end

	always_comb begin
		sts.cur_tag = rdata;
		sts.word_next = {word_q[23:0], in_byte};
		sts.blob_one = (blob_q == 32'd1);
		sts.tag_count = tag_count_q;
		sts.cur_arg = cur_arg_q;
		sts.tags_full = (tag_count_q >= MaxArgsC);
		sts.args_left = (cur_arg_q < tag_count_q) && (cur_arg_q < MaxArgsC);
		sts.err = err_q;
		sts.align = align_q;
	end
endmodule
`default_nettype wire

FILE: rtl/core/osc_controller.sv
// ---------------------------------------------------------------------------
// OSC parser controller
// Phase machine: takes bytes, walks data-less arguments, drives the result.
// ---------------------------------------------------------------------------
`default_nettype none
module osc_controller (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire osc_pkg::item_t in_item,
	output logic out_valid,
	input wire logic out_ready,
	output osc_pkg::result_t out_res,
	output logic adv_align,
	output osc_pkg::dp_cmd_t cmd,
	input wire osc_pkg::dp_sts_t sts
);
	import osc_pkg::*;

	typedef enum logic [1:0] {C_TAKE, C_WALK, C_FIN} ctl_t;

	ctl_t ctl_q;
	phase_t phase_q, nphase;
	logic fin_q, take, emit, walk, walk_start, free, out_load, pend_q;
	result_t res, out_data, pend_res_q;
	logic [1:0] na;
	logic aligned;

	assign na = sts.align + 2'd1;
	assign aligned = (na == 2'd0);
	assign free = !(out_valid && !out_ready);
	assign in_ready = (ctl_q == C_TAKE) && free;
	assign take = in_valid && in_ready;
	assign adv_align = take;
	assign walk = (ctl_q == C_WALK) && sts.args_left && is_dataless(sts.cur_tag);

	function automatic logic [3:0] end_status(input phase_t p, input logic [3:0] e);
		case (p)
			PH_ADDR, PH_ADDR_PAD: return ST_ADDR_SHORT;
			PH_COMMA, PH_RAW, PH_DONE: return ST_OK;
			PH_TAGS, PH_TAGS_PAD: return ST_TAGS_SHORT;
			PH_INT: return ST_INT_SHORT;
			PH_FLOAT: return ST_FLOAT_SHORT;
			PH_BSIZE: return ST_BSIZE_SHORT;
			PH_BDATA: return ST_BDATA_SHORT;
			PH_STR, PH_STR_PAD, PH_BPAD: return ST_OVERFLOW;
			default: return e;
		endcase
	endfunction

	// One walk step resolves the current argument: a data-less tag is reported
	// and the index moves on; a data tag selects its phase; an unknown tag skips.
	always_comb begin
		cmd = '0;
		res = '0;
		emit = 1'b0;
		nphase = phase_q;
		walk_start = 1'b0;
		if (ctl_q == C_TAKE && take) begin
			case (phase_q)
				PH_ADDR: begin
					emit = 1'b1;
					res.kind = KIND_ADDR;
					res.payload_byte = in_item.in_byte;
					res.field_end = (in_item.in_byte == 8'd0);
					if (in_item.in_byte == 8'd0) begin
						nphase = aligned ? PH_COMMA : PH_ADDR_PAD;
					end
				end
				PH_ADDR_PAD: if (aligned) nphase = PH_COMMA;
				PH_COMMA: nphase = (in_item.in_byte == CH_COMMA) ? PH_TAGS : PH_RAW;
				PH_TAGS, PH_TAGS_PAD: begin
					if (phase_q == PH_TAGS && in_item.in_byte != 8'd0) begin
						cmd.store_tag = 1'b1;
						cmd.set_too_many = sts.tags_full;
					end else if (aligned) begin
						if (sts.err == ST_TOO_MANY) begin
							nphase = PH_SKIP;
						end else begin
							cmd.zero_arg = 1'b1;
							walk_start = 1'b1;
						end
					end else begin
						nphase = PH_TAGS_PAD;
					end
				end
				PH_INT, PH_FLOAT, PH_BSIZE: begin
					cmd.shift_word = 1'b1;
					if (aligned) begin
						emit = 1'b1;
						res.kind = KIND_SCALAR;
						res.arg_number = sts.cur_arg;
						res.tag = sts.cur_tag;
						res.word_value = sts.word_next;
						if (phase_q == PH_BSIZE && sts.word_next != 32'd0) begin
							cmd.load_blob = 1'b1;
							nphase = PH_BDATA;
						end else begin
							cmd.inc_arg = 1'b1;
							walk_start = 1'b1;
						end
					end
				end
				PH_STR: begin
					emit = 1'b1;
					res.kind = KIND_STR;
					res.arg_number = sts.cur_arg;
					res.tag = CH_S;
					res.payload_byte = in_item.in_byte;
					res.field_end = (in_item.in_byte == 8'd0);
					if (in_item.in_byte == 8'd0) begin
						if (aligned) begin
							cmd.inc_arg = 1'b1;
							walk_start = 1'b1;
						end else begin
							nphase = PH_STR_PAD;
						end
					end
				end
				PH_BDATA: begin
					emit = 1'b1;
					res.kind = KIND_BLOB;
					res.arg_number = sts.cur_arg;
					res.tag = CH_B;
					res.payload_byte = in_item.in_byte;
					res.field_end = sts.blob_one;
					cmd.dec_blob = 1'b1;
					if (sts.blob_one) begin
						if (aligned) begin
							cmd.inc_arg = 1'b1;
							walk_start = 1'b1;
						end else begin
							nphase = PH_BPAD;
						end
					end
				end
				PH_STR_PAD, PH_BPAD: begin
					if (aligned) begin
						cmd.inc_arg = 1'b1;
						walk_start = 1'b1;
					end
				end
				default: ;
			endcase
			res.last_result = !walk_start && !in_item.final_byte;
			if (walk_start) begin
				nphase = PH_DONE;
			end
		end else if (ctl_q == C_WALK) begin
			cmd.clear_word = 1'b1;
			if (!sts.args_left) begin
				nphase = PH_DONE;
			end else if (is_dataless(sts.cur_tag)) begin
				res.kind = KIND_SCALAR;
				res.arg_number = sts.cur_arg;
				res.tag = sts.cur_tag;
				cmd.inc_arg = free;
			end else begin
				case (sts.cur_tag)
					CH_I: nphase = PH_INT;
					CH_F: nphase = PH_FLOAT;
					CH_S: nphase = PH_STR;
					CH_B: nphase = PH_BSIZE;
					default: begin
						nphase = PH_SKIP;
						cmd.set_unknown = 1'b1;
					end
				endcase
			end
			res.last_result = 1'b0;
		end else if (ctl_q == C_FIN) begin
			res.kind = KIND_DONE;
			res.arg_number = sts.tag_count;
			res.status = end_status(phase_q, sts.err);
			res.last_result = 1'b1;
			cmd.clear = free;
		end
	end

	// During a walk one record is held back until it is known whether another
	// record of the same beat follows it.
	always_comb begin
		out_load = 1'b0;
		out_data = res;
		case (ctl_q)
			C_TAKE: out_load = take && emit && !walk_start;
			C_WALK: begin
				out_load = free && pend_q;
				out_data = pend_res_q;
				if (!walk) begin
					out_data.last_result = !fin_q;
				end
			end
			C_FIN: out_load = free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= C_TAKE;
			phase_q <= PH_ADDR;
			fin_q <= 1'b0;
			out_valid <= 1'b0;
			out_res <= '0;
			pend_q <= 1'b0;
			pend_res_q <= '0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
				out_res <= out_data;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (ctl_q)
				C_TAKE: begin
					if (take) begin
						phase_q <= nphase;
						fin_q <= in_item.final_byte;
						if (walk_start) begin
							ctl_q <= C_WALK;
							pend_q <= emit;
							pend_res_q <= res;
						end else if (in_item.final_byte) begin
							ctl_q <= C_FIN;
						end
					end
				end
				C_WALK: begin
					if (free) begin
						phase_q <= nphase;
						if (walk) begin
							pend_q <= 1'b1;
							pend_res_q <= res;
						end else begin
							pend_q <= 1'b0;
							if (fin_q) begin
								ctl_q <= C_FIN;
							end else begin
								ctl_q <= C_TAKE;
							end
						end
					end
				end
				C_FIN: begin
					if (free) begin
						ctl_q <= C_TAKE;
						phase_q <= PH_ADDR;
						fin_q <= 1'b0;
					end
				end
				default: ctl_q <= C_TAKE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/osc_message_parser.sv
// ---------------------------------------------------------------------------
// OSC message parser
// Streams an OSC 1.0 message byte by byte and reports its fields.
// ---------------------------------------------------------------------------
// Channel  Role    Beat
// in_ch    sink    in_byte, final_byte
// out_ch   source  kind, arg_number, tag, word_value, payload_byte, field_end,
//                  status, last_result
//
// Bytes are taken only while the controller is not walking or sending the
// done record. When a field or the tag string ends, the controller walk
// reports each data-less argument reached and stops at the tag that ends the
// walk; the done record follows the final byte. The input is held off while
// the output register holds an unaccepted beat, and the walk and done record
// wait for it too. Reset returns to the address phase.
// ---------------------------------------------------------------------------
`default_nettype none
module osc_message_parser #(
	parameter int MaxArgs = osc_pkg::MaxArgsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	osc_stream_if.sink in_ch,
	osc_stream_if.source out_ch
);
	import osc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic adv_align, ctl_in_ready;
	item_t item;
	result_t res;
	logic res_valid;

	assign item.in_byte = in_ch.data.in_byte;
	assign item.final_byte = in_ch.data.final_byte;
	assign in_ch.ready = ctl_in_ready;
	assign out_ch.valid = res_valid;
	assign out_ch.data = res;

	osc_controller u_ctl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(ctl_in_ready), .in_item(item),
		.out_valid(res_valid), .out_ready(out_ch.ready), .out_res(res),
		.adv_align(adv_align), .cmd(cmd), .sts(sts)
	);

	osc_datapath #(.MaxArgs(MaxArgs)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_byte(item.in_byte),
		.adv_align(adv_align), .cmd(cmd), .sts(sts)
	);
endmodule
`default_nettype wire
